// ----- src/ptct_pkg.sv -----
// Shared types, constants and register codes for the pan/tilt centroid tracker.
// No dependencies; every other file imports this package.
package ptct_pkg;

  // Frame geometry
  localparam int FRAME_W = 384;
  localparam int FRAME_H = 288;

  // Field widths
  localparam int AREA_W     = 25;
  localparam int MOM_W      = 34;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 8;
  localparam int POS_W      = 10;
  localparam int STAT_W     = 2;
  localparam int CX_W       = 9;
  localparam int CY_W       = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // Datapath widths
  localparam int DIV_CNT_W = $clog2(MOM_W + 1);
  localparam int ERR_W     = CX_W + 1;
  localparam int DIF_W     = ERR_W + 1;
  localparam int P_W       = ERR_W + GAIN_W + 1;
  localparam int D_W       = DIF_W + GAIN_W + 1;
  localparam int SUM_W     = D_W + 1;
  localparam int PD_W      = 28;
  localparam int OP_W      = 12;
  localparam int FRAC_W    = 16;
  localparam int S_W       = OP_W + FRAC_W + 2;
  localparam int T_W       = S_W - FRAC_W;
  localparam int STEPX_W   = 6;
  localparam int STEPY_W   = 5;

  // Cell bounds
  localparam int COL_T1 = FRAME_W / 3;
  localparam int COL_T2 = (FRAME_W / 3) * 2;
  localparam int ROW_T1 = FRAME_H / 3;
  localparam int ROW_T2 = (FRAME_H / 3) * 2;
  localparam int MID_X  = FRAME_W / 2;
  localparam int MID_Y  = FRAME_H / 2;

  // Servo and base limits
  localparam int PAN_MIN    = 262;
  localparam int PAN_MAX    = 650;
  localparam int TILT_MIN   = 0;
  localparam int TILT_MAX   = 512;
  localparam int BASE_MAX   = 1023;
  localparam int BASE_RESET = 512;
  localparam int STEP_PAN   = 16;
  localparam int STEP_TILT  = 10;
  localparam int PD_MAX     = 134217727;
  localparam int PD_MIN     = -134217728;

  // Queue depth between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Track status codes
  localparam logic [STAT_W-1:0] ST_SEEN  = 2'd0;
  localparam logic [STAT_W-1:0] ST_COAST = 2'd1;
  localparam logic [STAT_W-1:0] ST_LOST  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_D      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_P     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_D     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_THR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT = 3'd5;

  // Register reset values
  localparam logic [GAIN_W-1:0]  RST_PAN_P      = 16'd3834;
  localparam logic [GAIN_W-1:0]  RST_PAN_D      = 16'd1311;
  localparam logic [GAIN_W-1:0]  RST_TILT_P     = 16'd2621;
  localparam logic [GAIN_W-1:0]  RST_TILT_D     = 16'd1966;
  localparam logic [AREA_W-1:0]  RST_AREA_THR   = 25'd10000;
  localparam logic [LIMIT_W-1:0] RST_LOST_LIMIT = 8'd15;

  typedef struct packed {
    logic [GAIN_W-1:0]  pan_p_gain;
    logic [GAIN_W-1:0]  pan_d_gain;
    logic [GAIN_W-1:0]  tilt_p_gain;
    logic [GAIN_W-1:0]  tilt_d_gain;
    logic [AREA_W-1:0]  area_threshold;
    logic [LIMIT_W-1:0] lost_limit;
  } cfg_t;

  // One classified frame as it travels from front to back
  typedef struct packed {
    logic              seen;
    logic [AREA_W-1:0] area;
    logic [MOM_W-1:0]  mx;
    logic [MOM_W-1:0]  my;
  } item_t;

endpackage

// ----- src/ptct_front.sv -----
// Front end: accepts a frame's moment sums and classifies it as seen or lost.
// Depends on ptct_pkg; feeds ptct_queue.
module ptct_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ptct_pkg::AREA_W-1:0]   in_area_sum,
  input  logic [ptct_pkg::MOM_W-1:0]    in_x_moment,
  input  logic [ptct_pkg::MOM_W-1:0]    in_y_moment,
  input  logic [ptct_pkg::AREA_W-1:0]   area_threshold,
  input  logic                          q_full,
  output logic                          q_push,
  output ptct_pkg::item_t               q_item
);
  import ptct_pkg::*;

  logic  stage_valid_r;
  item_t stage_r;
  logic  accept;

  // Hold the staged item while the queue is full
  assign q_push   = stage_valid_r && !q_full;
  assign in_stall = stage_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_item   = stage_r;

  // Track stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (accept) begin
      stage_valid_r <= 1'b1;
    end else if (q_push) begin
      stage_valid_r <= 1'b0;
    end
  end

  // Classify and capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r.seen <= (in_area_sum >= area_threshold);
      stage_r.area <= in_area_sum;
      stage_r.mx   <= in_x_moment;
      stage_r.my   <= in_y_moment;
    end
  end

endmodule

// ----- src/ptct_queue.sv -----
// Short queue of classified items between front and back.
// Depends on ptct_pkg.
module ptct_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ptct_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output ptct_pkg::item_t head
);
  import ptct_pkg::*;

  item_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/ptct_back.sv -----
// Back end: centroid division, cell steps, PD terms, servo commands, result register.
// Depends on ptct_pkg; takes items from ptct_queue.
module ptct_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptct_pkg::cfg_t                cfg,
  input  logic                          q_empty,
  input  ptct_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ptct_pkg::POS_W-1:0]    out_pan_position,
  output logic [ptct_pkg::POS_W-1:0]    out_tilt_position,
  output logic [ptct_pkg::STAT_W-1:0]   out_track_status,
  output logic [ptct_pkg::CX_W-1:0]     out_centroid_x,
  output logic [ptct_pkg::CY_W-1:0]     out_centroid_y
);
  import ptct_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_CELL  = 4'd2;
  localparam logic [3:0] S_MULP  = 4'd3;
  localparam logic [3:0] S_MULD  = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_CMD   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]                state_r;
  logic [DIV_CNT_W-1:0]      cnt_r;

  // Divider lanes
  logic [AREA_W-1:0]         area_r;
  logic [MOM_W-1:0]          quo_x_r, quo_y_r;
  logic [AREA_W-1:0]         rem_x_r, rem_y_r;
  logic [AREA_W:0]           sh_x, sh_y;
  logic                      ge_x, ge_y;
  logic [AREA_W:0]           sub_x, sub_y;
  logic [AREA_W-1:0]         rem_x_nxt, rem_y_nxt;
  logic [MOM_W-1:0]          quo_x_nxt, quo_y_nxt;

  // Tracking state
  logic [CX_W-1:0]           cx_r;
  logic [CY_W-1:0]           cy_r;
  logic signed [STEPX_W-1:0] step_x_r;
  logic signed [STEPY_W-1:0] step_y_r;
  logic [POS_W-1:0]          pan_base_r, tilt_base_r;
  logic [POS_W-1:0]          pan_cmd_r, tilt_cmd_r;
  logic signed [ERR_W-1:0]   prev_ex_r, prev_ey_r;
  logic signed [PD_W-1:0]    pd_x_r, pd_y_r;
  logic [LIMIT_W-1:0]        lost_cnt_r;
  logic [STAT_W-1:0]         status_r;

  // Per-frame working registers
  logic signed [ERR_W-1:0]   err_x_r, err_y_r;
  logic signed [P_W-1:0]     prod_px_r, prod_py_r;
  logic signed [D_W-1:0]     prod_dx_r, prod_dy_r;
  logic signed [OP_W-1:0]    op_x_r, op_y_r;

  // Result register
  logic                      out_valid_r;
  logic [POS_W-1:0]          out_pan_r, out_tilt_r;
  logic [STAT_W-1:0]         out_status_r;
  logic [CX_W-1:0]           out_cx_r;
  logic [CY_W-1:0]           out_cy_r;

  // Cell decode and arithmetic
  logic [CX_W-1:0]           cx_nxt;
  logic [CY_W-1:0]           cy_nxt;
  logic signed [STEPX_W-1:0] step_x_nxt;
  logic signed [STEPY_W-1:0] step_y_nxt;
  logic signed [OP_W-1:0]    base_x_sum, base_y_sum;
  logic [POS_W-1:0]          pan_base_nxt, tilt_base_nxt;
  logic signed [DIF_W-1:0]   dif_x, dif_y;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic signed [S_W-1:0]     s_x, s_y, sa_x, sa_y;
  logic signed [T_W-1:0]     t_x, t_y;
  logic [POS_W-1:0]          pan_cmd_nxt, tilt_cmd_nxt;
  logic                      out_free;

  function automatic logic signed [PD_W-1:0] pd_sat(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(PD_MAX)) begin
      pd_sat = PD_W'(PD_MAX);
    end else if (v < SUM_W'(PD_MIN)) begin
      pd_sat = PD_W'(PD_MIN);
    end else begin
      pd_sat = v[PD_W-1:0];
    end
  endfunction

  function automatic logic [POS_W-1:0] base_clamp(input logic signed [OP_W-1:0] v);
    if (v < 0) begin
      base_clamp = '0;
    end else if (v > OP_W'(BASE_MAX)) begin
      base_clamp = POS_W'(BASE_MAX);
    end else begin
      base_clamp = v[POS_W-1:0];
    end
  endfunction

  function automatic logic signed [S_W-1:0] round_in(input logic signed [S_W-1:0] s);
    // bias negative sums so the arithmetic shift truncates toward zero
    round_in = s[S_W-1] ? s + S_W'((1 << FRAC_W) - 1) : s;
  endfunction

  // One restoring step per lane
  assign sh_x      = {rem_x_r, quo_x_r[MOM_W-1]};
  assign sh_y      = {rem_y_r, quo_y_r[MOM_W-1]};
  assign ge_x      = (sh_x >= {1'b0, area_r});
  assign ge_y      = (sh_y >= {1'b0, area_r});
  assign sub_x     = sh_x - {1'b0, area_r};
  assign sub_y     = sh_y - {1'b0, area_r};
  assign rem_x_nxt = ge_x ? sub_x[AREA_W-1:0] : sh_x[AREA_W-1:0];
  assign rem_y_nxt = ge_y ? sub_y[AREA_W-1:0] : sh_y[AREA_W-1:0];
  assign quo_x_nxt = {quo_x_r[MOM_W-2:0], ge_x};
  assign quo_y_nxt = {quo_y_r[MOM_W-2:0], ge_y};

  // Saturate the quotients into the frame and pick the cell steps
  always_comb begin
    cx_nxt = (quo_x_r > MOM_W'(FRAME_W - 1)) ? CX_W'(FRAME_W - 1) : quo_x_r[CX_W-1:0];
    cy_nxt = (quo_y_r > MOM_W'(FRAME_H - 1)) ? CY_W'(FRAME_H - 1) : quo_y_r[CY_W-1:0];
    priority if (cx_nxt <= CX_W'(COL_T1)) begin
      step_x_nxt = STEPX_W'(STEP_PAN);
    end else if (cx_nxt <= CX_W'(COL_T2)) begin
      step_x_nxt = '0;
    end else begin
      step_x_nxt = -STEPX_W'(STEP_PAN);
    end
    priority if (cy_nxt <= CY_W'(ROW_T1)) begin
      step_y_nxt = STEPY_W'(STEP_TILT);
    end else if (cy_nxt <= CY_W'(ROW_T2)) begin
      step_y_nxt = '0;
    end else begin
      step_y_nxt = -STEPY_W'(STEP_TILT);
    end
    base_x_sum    = $signed({{(OP_W-POS_W){1'b0}}, pan_base_r}) + OP_W'(step_x_nxt);
    base_y_sum    = $signed({{(OP_W-POS_W){1'b0}}, tilt_base_r}) + OP_W'(step_y_nxt);
    pan_base_nxt  = base_clamp(base_x_sum);
    tilt_base_nxt = base_clamp(base_y_sum);
  end

  // Error differences and PD sums
  assign dif_x = DIF_W'(err_x_r) - DIF_W'(prev_ex_r);
  assign dif_y = DIF_W'(err_y_r) - DIF_W'(prev_ey_r);
  assign sum_x = SUM_W'(prod_px_r) + SUM_W'(prod_dx_r);
  assign sum_y = SUM_W'(prod_py_r) + SUM_W'(prod_dy_r);

  // Command: integer part toward zero of base plus Q11.16 term, then clamp
  always_comb begin
    s_x  = (S_W'(op_x_r) <<< FRAC_W) + S_W'(pd_x_r);
    s_y  = (S_W'(op_y_r) <<< FRAC_W) + S_W'(pd_y_r);
    sa_x = round_in(s_x);
    sa_y = round_in(s_y);
    t_x  = sa_x[S_W-1:FRAC_W];
    t_y  = sa_y[S_W-1:FRAC_W];
    priority if (t_x < T_W'(PAN_MIN)) begin
      pan_cmd_nxt = POS_W'(PAN_MIN);
    end else if (t_x > T_W'(PAN_MAX)) begin
      pan_cmd_nxt = POS_W'(PAN_MAX);
    end else begin
      pan_cmd_nxt = t_x[POS_W-1:0];
    end
    priority if (t_y < T_W'(TILT_MIN)) begin
      tilt_cmd_nxt = POS_W'(TILT_MIN);
    end else if (t_y > T_W'(TILT_MAX)) begin
      tilt_cmd_nxt = POS_W'(TILT_MAX);
    end else begin
      tilt_cmd_nxt = t_y[POS_W-1:0];
    end
  end

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      step_x_r    <= '0;
      step_y_r    <= '0;
      pan_base_r  <= POS_W'(BASE_RESET);
      tilt_base_r <= POS_W'(BASE_RESET);
      pan_cmd_r   <= POS_W'(BASE_RESET);
      tilt_cmd_r  <= POS_W'(BASE_RESET);
      prev_ex_r   <= '0;
      prev_ey_r   <= '0;
      pd_x_r      <= '0;
      pd_y_r      <= '0;
      lost_cnt_r  <= '0;
      status_r    <= ST_SEEN;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_item.seen) begin
              cnt_r   <= '0;
              state_r <= S_DIV;
            end else if (lost_cnt_r >= cfg.lost_limit) begin
              lost_cnt_r <= '0;
              status_r   <= ST_LOST;
              state_r    <= S_OUT;
            end else begin
              lost_cnt_r <= lost_cnt_r + 1'b1;
              status_r   <= ST_COAST;
              state_r    <= S_CMD;
            end
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_CNT_W'(MOM_W - 1)) begin
            state_r <= S_CELL;
          end
        end
        S_CELL: begin
          cx_r        <= cx_nxt;
          cy_r        <= cy_nxt;
          step_x_r    <= step_x_nxt;
          step_y_r    <= step_y_nxt;
          pan_base_r  <= pan_base_nxt;
          tilt_base_r <= tilt_base_nxt;
          lost_cnt_r  <= '0;
          status_r    <= ST_SEEN;
          state_r     <= S_MULP;
        end
        S_MULP: begin
          state_r <= S_MULD;
        end
        S_MULD: begin
          prev_ex_r <= err_x_r;
          prev_ey_r <= err_y_r;
          state_r   <= S_SUM;
        end
        S_SUM: begin
          pd_x_r  <= pd_sat(sum_x);
          pd_y_r  <= pd_sat(sum_y);
          state_r <= S_CMD;
        end
        S_CMD: begin
          pan_cmd_r  <= pan_cmd_nxt;
          tilt_cmd_r <= tilt_cmd_nxt;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers of the datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        area_r  <= q_item.area;
        quo_x_r <= q_item.mx;
        quo_y_r <= q_item.my;
        rem_x_r <= '0;
        rem_y_r <= '0;
        // coasting adds the last step to the last command
        op_x_r  <= $signed({{(OP_W-POS_W){1'b0}}, pan_cmd_r}) + OP_W'(step_x_r);
        op_y_r  <= $signed({{(OP_W-POS_W){1'b0}}, tilt_cmd_r}) + OP_W'(step_y_r);
      end
      S_DIV: begin
        quo_x_r <= quo_x_nxt;
        quo_y_r <= quo_y_nxt;
        rem_x_r <= rem_x_nxt;
        rem_y_r <= rem_y_nxt;
      end
      S_CELL: begin
        err_x_r <= ERR_W'(MID_X) - $signed({1'b0, cx_nxt});
        err_y_r <= ERR_W'(MID_Y) - $signed({1'b0, cy_nxt});
        op_x_r  <= $signed({{(OP_W-POS_W){1'b0}}, pan_base_nxt});
        op_y_r  <= $signed({{(OP_W-POS_W){1'b0}}, tilt_base_nxt});
      end
      S_MULP: begin
        // drop the proportional part on an axis with no step
        prod_px_r <= (step_x_r == '0) ? P_W'(0) : err_x_r * $signed({1'b0, cfg.pan_p_gain});
        prod_py_r <= (step_y_r == '0) ? P_W'(0) : err_y_r * $signed({1'b0, cfg.tilt_p_gain});
      end
      S_MULD: begin
        prod_dx_r <= dif_x * $signed({1'b0, cfg.pan_d_gain});
        prod_dy_r <= dif_y * $signed({1'b0, cfg.tilt_d_gain});
      end
      default: begin
      end
    endcase
  end

  // Result register: load when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_pan_r    <= pan_cmd_r;
      out_tilt_r   <= tilt_cmd_r;
      out_status_r <= status_r;
      out_cx_r     <= cx_r;
      out_cy_r     <= cy_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pan_position  = out_pan_r;
  assign out_tilt_position = out_tilt_r;
  assign out_track_status  = out_status_r;
  assign out_centroid_x    = out_cx_r;
  assign out_centroid_y    = out_cy_r;

endmodule

// ----- src/pan_tilt_centroid_tracker.sv -----
// Top level of the pan/tilt centroid tracker: register file, front, queue and back.
// Depends on ptct_pkg, ptct_front, ptct_queue and ptct_back.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | area_sum, x_moment, y_moment
//   out_    | output    | out_valid/out_stall| pan/tilt position, status, centroid
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// A seen item passes the front stage and queue, a pop, 34 divider steps, then cell,
// two multiply, sum, command and output steps to the result register; the back takes
// no new item until its output step hands the result on. A coasting item goes via
// command and output, a lost-limit item only via output. Synchronous active-low
// reset returns all tracking state to its start values. The front and a two-item
// queue keep taking items while the back works or the result waits under out_stall.
module pan_tilt_centroid_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ptct_pkg::AREA_W-1:0]       in_area_sum,
  input  logic [ptct_pkg::MOM_W-1:0]        in_x_moment,
  input  logic [ptct_pkg::MOM_W-1:0]        in_y_moment,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ptct_pkg::POS_W-1:0]        out_pan_position,
  output logic [ptct_pkg::POS_W-1:0]        out_tilt_position,
  output logic [ptct_pkg::STAT_W-1:0]       out_track_status,
  output logic [ptct_pkg::CX_W-1:0]         out_centroid_x,
  output logic [ptct_pkg::CY_W-1:0]         out_centroid_y,
  input  logic                              cfg_we,
  input  logic [ptct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptct_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ptct_pkg::*;

  cfg_t  cfg_r;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  item_t q_in;
  item_t q_head;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pan_p_gain     <= RST_PAN_P;
      cfg_r.pan_d_gain     <= RST_PAN_D;
      cfg_r.tilt_p_gain    <= RST_TILT_P;
      cfg_r.tilt_d_gain    <= RST_TILT_D;
      cfg_r.area_threshold <= RST_AREA_THR;
      cfg_r.lost_limit     <= RST_LOST_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAN_P:      cfg_r.pan_p_gain     <= cfg_data[GAIN_W-1:0];
        REG_PAN_D:      cfg_r.pan_d_gain     <= cfg_data[GAIN_W-1:0];
        REG_TILT_P:     cfg_r.tilt_p_gain    <= cfg_data[GAIN_W-1:0];
        REG_TILT_D:     cfg_r.tilt_d_gain    <= cfg_data[GAIN_W-1:0];
        REG_AREA_THR:   cfg_r.area_threshold <= cfg_data[AREA_W-1:0];
        REG_LOST_LIMIT: cfg_r.lost_limit     <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ptct_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_area_sum    (in_area_sum),
    .in_x_moment    (in_x_moment),
    .in_y_moment    (in_y_moment),
    .area_threshold (cfg_r.area_threshold),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  ptct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  ptct_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_item            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pan_position  (out_pan_position),
    .out_tilt_position (out_tilt_position),
    .out_track_status  (out_track_status),
    .out_centroid_x    (out_centroid_x),
    .out_centroid_y    (out_centroid_y)
  );

endmodule

// ----- tb/pan_tilt_centroid_tracker_tb.sv -----
// Self-checking testbench for the pan/tilt centroid tracker.
// Depends on ptct_pkg and pan_tilt_centroid_tracker; predicts every frame's servo
// result in-bench and checks it against the block under random idling on both sides.
`timescale 1ns / 1ps

module pan_tilt_centroid_tracker_tb;
  import ptct_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint unsigned AREA_MAX = (64'd1 << AREA_W) - 1;
  localparam longint unsigned MOM_MAX  = (64'd1 << MOM_W) - 1;
  localparam logic [AREA_W-1:0] AREA_FULL = '1;
  localparam logic [MOM_W-1:0]  MOM_FULL  = '1;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [MOM_W-1:0]  mx;
    logic [MOM_W-1:0]  my;
  } frame_t;

  typedef struct packed {
    logic [POS_W-1:0]  pan;
    logic [POS_W-1:0]  tilt;
    logic [STAT_W-1:0] status;
    logic [CX_W-1:0]   cx;
    logic [CY_W-1:0]   cy;
  } servo_result_t;

  // Block ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [AREA_W-1:0]     in_area_sum = '0;
  logic [MOM_W-1:0]      in_x_moment = '0;
  logic [MOM_W-1:0]      in_y_moment = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [POS_W-1:0]      out_pan_position;
  logic [POS_W-1:0]      out_tilt_position;
  logic [STAT_W-1:0]     out_track_status;
  logic [CX_W-1:0]       out_centroid_x;
  logic [CY_W-1:0]       out_centroid_y;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Stimulus and expectation stores
  frame_t        pending_frames[$];
  servo_result_t expected_moves[$];
  frame_t        drive_frame;
  int            mismatch_count = 0;
  int            cycle_count = 0;

  // Handshake bookkeeping
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;

  // Tracker mirror: configuration and state
  cfg_t track_cfg = '{RST_PAN_P, RST_PAN_D, RST_TILT_P, RST_TILT_D,
                      RST_AREA_THR, RST_LOST_LIMIT};
  int               pan_anchor = BASE_RESET;
  int               tilt_anchor = BASE_RESET;
  int               pan_goal = BASE_RESET;
  int               tilt_goal = BASE_RESET;
  int               pan_nudge = 0;
  int               tilt_nudge = 0;
  int               pan_err_prev = 0;
  int               tilt_err_prev = 0;
  longint           pan_pd = 0;
  longint           tilt_pd = 0;
  logic [LIMIT_W-1:0] miss_count = '0;
  logic [CX_W-1:0]  held_cx = '0;
  logic [CY_W-1:0]  held_cy = '0;

  pan_tilt_centroid_tracker u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_area_sum       (in_area_sum),
    .in_x_moment       (in_x_moment),
    .in_y_moment       (in_y_moment),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pan_position  (out_pan_position),
    .out_tilt_position (out_tilt_position),
    .out_track_status  (out_track_status),
    .out_centroid_x    (out_centroid_x),
    .out_centroid_y    (out_centroid_y),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int clamp_to(longint v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Integer part, toward zero, of whole + frac where frac is Q.16
  function automatic longint q16_trunc(longint whole, longint frac);
    longint s;
    s = whole * (longint'(1) <<< FRAC_W) + frac;
    if (s < 0) return -((-s) >>> FRAC_W);
    return s >>> FRAC_W;
  endfunction

  // Divide, saturating at the last pixel; zero area reads as all ones
  function automatic int centroid_of(logic [MOM_W-1:0] m, logic [AREA_W-1:0] a, int size);
    longint unsigned q;
    if (a == 0) q = '1;
    else q = m / a;
    if (q > longint'(size - 1)) q = size - 1;
    return int'(q);
  endfunction

  // Step for the third of the frame that holds v
  function automatic int nudge_for(int v, int size, int step);
    if (v <= size / 3) return step;
    if (v <= (size / 3) * 2) return 0;
    return -step;
  endfunction

  function automatic longint pd_sum(int err, int err_prev, int nudge, longint kp, longint kd);
    longint prop, deriv, total;
    prop  = (nudge == 0) ? 0 : longint'(err) * kp;
    deriv = longint'(err - err_prev) * kd;
    total = prop + deriv;
    if (total > PD_MAX) total = PD_MAX;
    if (total < PD_MIN) total = PD_MIN;
    return total;
  endfunction

  // Advance the mirror by one frame and return the servo result it gives
  function automatic servo_result_t advance_tracker(frame_t f);
    servo_result_t r;
    int cx, cy, ex, ey;
    logic [STAT_W-1:0] status;
    if (f.area < track_cfg.area_threshold) begin
      if (miss_count >= track_cfg.lost_limit) begin
        miss_count = '0;
        status = ST_LOST;
      end else begin
        miss_count = miss_count + 1'b1;
        pan_goal  = clamp_to(q16_trunc(pan_goal + pan_nudge, pan_pd), PAN_MIN, PAN_MAX);
        tilt_goal = clamp_to(q16_trunc(tilt_goal + tilt_nudge, tilt_pd), TILT_MIN, TILT_MAX);
        status = ST_COAST;
      end
    end else begin
      cx = centroid_of(f.mx, f.area, FRAME_W);
      cy = centroid_of(f.my, f.area, FRAME_H);
      miss_count = '0;
      held_cx = CX_W'(cx);
      held_cy = CY_W'(cy);
      pan_nudge  = nudge_for(cx, FRAME_W, STEP_PAN);
      tilt_nudge = nudge_for(cy, FRAME_H, STEP_TILT);
      ex = MID_X - cx;
      ey = MID_Y - cy;
      pan_anchor  = clamp_to(pan_anchor + pan_nudge, 0, BASE_MAX);
      tilt_anchor = clamp_to(tilt_anchor + tilt_nudge, 0, BASE_MAX);
      pan_pd  = pd_sum(ex, pan_err_prev, pan_nudge, track_cfg.pan_p_gain,
                       track_cfg.pan_d_gain);
      tilt_pd = pd_sum(ey, tilt_err_prev, tilt_nudge, track_cfg.tilt_p_gain,
                       track_cfg.tilt_d_gain);
      pan_goal  = clamp_to(q16_trunc(pan_anchor, pan_pd), PAN_MIN, PAN_MAX);
      tilt_goal = clamp_to(q16_trunc(tilt_anchor, tilt_pd), TILT_MIN, TILT_MAX);
      pan_err_prev  = ex;
      tilt_err_prev = ey;
      status = ST_SEEN;
    end
    r.pan    = POS_W'(pan_goal);
    r.tilt   = POS_W'(tilt_goal);
    r.status = status;
    r.cx     = held_cx;
    r.cy     = held_cy;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_move(servo_result_t got);
    servo_result_t want;
    if (expected_moves.size() == 0) begin
      if (mismatch_count < MAX_REPORTS)
        $display("[%0t] result with nothing expected: pan %0d tilt %0d st %0d cx %0d cy %0d",
                 $realtime, got.pan, got.tilt, got.status, got.cx, got.cy);
      mismatch_count++;
      return;
    end
    want = expected_moves.pop_front();
    if (got.pan !== want.pan || got.tilt !== want.tilt || got.status !== want.status ||
        got.cx !== want.cx || got.cy !== want.cy) begin
      if (mismatch_count < MAX_REPORTS)
        $display("[%0t] mismatch exp/got: pan %0d/%0d tilt %0d/%0d st %0d/%0d cx %0d/%0d cy %0d/%0d",
                 $realtime, want.pan, got.pan, want.tilt, got.tilt, want.status, got.status,
                 want.cx, got.cx, want.cy, got.cy);
      mismatch_count++;
    end
  endfunction

  // Watch both channels; predict on each accepted item, check each result
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken  <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (in_valid && !in_stall)
        expected_moves.push_back(advance_tracker(frame_t'{in_area_sum, in_x_moment,
                                                          in_y_moment}));
      if (out_valid && !out_stall)
        check_move(servo_result_t'{out_pan_position, out_tilt_position, out_track_status,
                                   out_centroid_x, out_centroid_y});
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(5, 0));
  endfunction

  // Feed items from the pending queue; hold a stalled item, then wait its gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) gap_left = draw_wait(in_calm);
      if (gap_left == 0 && pending_frames.size() != 0) begin
        drive_frame = pending_frames.pop_front();
        in_area_sum <= drive_frame.area;
        in_x_moment <= drive_frame.mx;
        in_y_moment <= drive_frame.my;
        in_valid    <= 1'b1;
        if ($urandom_range(39, 0) == 0) in_calm = !in_calm;
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end
    end
  end

  // Stall the result side for a random count after each accepted result
  always @(negedge clk) begin
    if (out_taken) begin
      stall_left = draw_wait(out_calm);
      if ($urandom_range(29, 0) == 0) out_calm = !out_calm;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Write one register; call at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PAN_P:      track_cfg.pan_p_gain     = val[GAIN_W-1:0];
      REG_PAN_D:      track_cfg.pan_d_gain     = val[GAIN_W-1:0];
      REG_TILT_P:     track_cfg.tilt_p_gain    = val[GAIN_W-1:0];
      REG_TILT_D:     track_cfg.tilt_d_gain    = val[GAIN_W-1:0];
      REG_AREA_THR:   track_cfg.area_threshold = val[AREA_W-1:0];
      REG_LOST_LIMIT: track_cfg.lost_limit     = val[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [GAIN_W-1:0] pp, input logic [GAIN_W-1:0] pdg,
                               input logic [GAIN_W-1:0] tp, input logic [GAIN_W-1:0] tdg,
                               input logic [AREA_W-1:0] thr, input logic [LIMIT_W-1:0] lim);
    write_reg(REG_PAN_P, CFG_DATA_W'(pp));
    write_reg(REG_PAN_D, CFG_DATA_W'(pdg));
    write_reg(REG_TILT_P, CFG_DATA_W'(tp));
    write_reg(REG_TILT_D, CFG_DATA_W'(tdg));
    write_reg(REG_AREA_THR, CFG_DATA_W'(thr));
    write_reg(REG_LOST_LIMIT, CFG_DATA_W'(lim));
  endtask

  // Wait until nothing is queued, driven or expected; end at a falling edge
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_frames.size() != 0 || in_valid || expected_moves.size() != 0);
    @(negedge clk);
  endtask

  function automatic logic [MOM_W-1:0] rand_moment();
    return MOM_W'({$urandom, $urandom});
  endfunction

  function automatic logic [MOM_W-1:0] moment_for(int c, longint unsigned a,
                                                  longint unsigned rem);
    longint unsigned m;
    m = longint'(c) * a + rem;
    if (m > MOM_MAX) m = MOM_MAX;
    return MOM_W'(m);
  endfunction

  function automatic frame_t exact_frame(int cx, int cy, longint unsigned a);
    return frame_t'{AREA_W'(a), moment_for(cx, a, 0), moment_for(cy, a, 0)};
  endfunction

  function automatic frame_t noise_frame();
    return frame_t'{AREA_W'($urandom), rand_moment(), rand_moment()};
  endfunction

  // Frame at or above the threshold whose centroid lands on (cx, cy)
  function automatic frame_t seen_frame(int cx, int cy);
    longint unsigned thr, a;
    frame_t f;
    thr = track_cfg.area_threshold;
    case ($urandom_range(3, 0))
      0:       a = thr;
      1:       a = $urandom_range(AREA_MAX, thr);
      default: a = thr + $urandom_range(200000, 0);
    endcase
    if (a > AREA_MAX) a = AREA_MAX;
    f.area = AREA_W'(a);
    if (a == 0) begin
      f.mx = rand_moment();
      f.my = rand_moment();
    end else begin
      f.mx = moment_for(cx, a, $urandom_range(a - 1, 0));
      f.my = moment_for(cy, a, $urandom_range(a - 1, 0));
    end
    return f;
  endfunction

  // Frame below the threshold, mostly a small blob
  function automatic frame_t missed_frame();
    longint unsigned thr, a;
    thr = track_cfg.area_threshold;
    if (thr == 0) return noise_frame();
    if ($urandom_range(1, 0)) a = $urandom_range(thr - 1, 0);
    else a = $urandom_range((thr - 1 < 2000) ? thr - 1 : 2000, 0);
    return frame_t'{AREA_W'(a), rand_moment(), rand_moment()};
  endfunction

  // Coordinate near the aim point, or anywhere including past the frame edge
  function automatic int pick_coord(int aim, int size);
    int v;
    if ($urandom_range(3, 0) != 0) v = aim + int'($urandom_range(40, 0)) - 20;
    else v = int'($urandom_range(size + 63, 0));
    return (v < 0) ? 0 : v;
  endfunction

  // Runs of seen frames that drift the bases, runs of misses up to and past the lost limit,
  // and some raw noise
  task automatic fill_random(input int count);
    int run_left, aim_x, aim_y, drift_x, drift_y;
    bit run_seen;
    frame_t f;
    drift_x  = $urandom_range(FRAME_W - 1, 0);
    drift_y  = $urandom_range(FRAME_H - 1, 0);
    run_left = 0;
    run_seen = 1'b1;
    aim_x    = drift_x;
    aim_y    = drift_y;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        run_seen = (track_cfg.area_threshold == 0) || ($urandom_range(2, 0) != 0);
        if (run_seen) run_left = $urandom_range(40, 1);
        else if ($urandom_range(1, 0)) run_left = int'(track_cfg.lost_limit) + 1;
        else run_left = $urandom_range(int'(track_cfg.lost_limit) + 3, 1);
        if ($urandom_range(1, 0)) begin
          aim_x = drift_x;
          aim_y = drift_y;
        end else begin
          aim_x = $urandom_range(FRAME_W - 1, 0);
          aim_y = $urandom_range(FRAME_H - 1, 0);
        end
      end
      run_left--;
      if ($urandom_range(9, 0) == 0) f = noise_frame();
      else if (run_seen) f = seen_frame(pick_coord(aim_x, FRAME_W), pick_coord(aim_y, FRAME_H));
      else f = missed_frame();
      pending_frames.push_back(f);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every cell, cell edges, saturation, threshold edge, coasting
    apply_setting(RST_PAN_P, RST_PAN_D, RST_TILT_P, RST_TILT_D, RST_AREA_THR, RST_LOST_LIMIT);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        pending_frames.push_back(exact_frame(64 + 128 * c, 48 + 96 * r, 25500));
    pending_frames.push_back(exact_frame(COL_T1, ROW_T1, 25500));
    pending_frames.push_back(exact_frame(COL_T1 + 1, ROW_T1 + 1, 25500));
    pending_frames.push_back(exact_frame(COL_T2, ROW_T2, 25500));
    pending_frames.push_back(exact_frame(COL_T2 + 1, ROW_T2 + 1, 25500));
    pending_frames.push_back(frame_t'{RST_AREA_THR, MOM_FULL, MOM_FULL});
    pending_frames.push_back(frame_t'{AREA_FULL, MOM_FULL, MOM_FULL});
    pending_frames.push_back(exact_frame(200, 150, RST_AREA_THR));
    pending_frames.push_back(frame_t'{RST_AREA_THR - 1'b1, MOM_FULL, MOM_W'(0)});
    pending_frames.push_back(frame_t'{AREA_W'(0), MOM_W'(0), MOM_W'(0)});
    wait_idle();

    // Directed: unused indexes leave the registers alone; lost limit of one
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    write_reg(REG_LOST_LIMIT, CFG_DATA_W'(1));
    repeat (3) pending_frames.push_back(frame_t'{AREA_W'(0), MOM_FULL, MOM_FULL});
    wait_idle();

    // Reset gains
    apply_setting(RST_PAN_P, RST_PAN_D, RST_TILT_P, RST_TILT_D, RST_AREA_THR, RST_LOST_LIMIT);
    fill_random(80);
    wait_idle();

    // Full gains, limit of zero drops on every miss
    apply_setting('1, '1, '1, '1, AREA_W'(255 * 20), LIMIT_W'(0));
    fill_random(80);
    wait_idle();

    // Zero gains and zero threshold: every frame is seen, zero area too
    apply_setting('0, '0, '0, '0, AREA_W'(0), LIMIT_W'(1));
    pending_frames.push_back(frame_t'{AREA_W'(0), MOM_W'(0), MOM_W'(0)});
    pending_frames.push_back(frame_t'{AREA_W'(0), MOM_FULL, MOM_FULL});
    fill_random(80);
    wait_idle();

    // Largest threshold and limit: one full coasting run to the lost reset
    apply_setting(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                  GAIN_W'($urandom), AREA_FULL, '1);
    repeat (int'(track_cfg.lost_limit) + 1) pending_frames.push_back(missed_frame());
    fill_random(40);
    wait_idle();

    // Random settings
    apply_setting(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                  GAIN_W'($urandom), AREA_W'($urandom_range(1 << 24, 0)),
                  LIMIT_W'($urandom_range(20, 1)));
    fill_random(100);
    wait_idle();

    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    apply_setting(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                  GAIN_W'($urandom), AREA_W'($urandom_range(300000, 20000)),
                  LIMIT_W'($urandom_range(8, 1)));
    fill_random(100);
    wait_idle();

    // Drain, then watch for stray results
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_moves.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
